>>> rtl/core/mfde_pkg.sv
// mfde_pkg: shared types, constants and helpers for the framebuffer draw engine
// no dependencies; imported by the top level, the controller and the datapath
`timescale 1ns / 1ps

package mfde_pkg;

  // default store geometry
  localparam int unsigned MAX_WIDTH_DEF  = 128;
  localparam int unsigned MAX_HEIGHT_DEF = 64;

  // configuration field widths and register indexes
  localparam int unsigned CFG_W_BITS = 8;
  localparam int unsigned CFG_H_BITS = 7;
  localparam logic        REG_WIDTH  = 1'b0;
  localparam logic        REG_HEIGHT = 1'b1;

  // byte index width: row (7 bits) times bytes per row (5 bits) plus column byte
  localparam int unsigned IDX_W = 12;

  // command codes
  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_PIXEL = 3'd1,
    OP_HLINE = 3'd2,
    OP_VLINE = 3'd3,
    OP_RECT  = 3'd4,
    OP_READ  = 3'd5
  } op_e;

  // outline segments in drawing order
  typedef enum logic [1:0] {
    SEG_TOP    = 2'd0,
    SEG_BOTTOM = 2'd1,
    SEG_LEFT   = 2'd2,
    SEG_RIGHT  = 2'd3
  } seg_e;

  // controller states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLR,
    ST_SEG,
    ST_PIX,
    ST_WR,
    ST_RD,
    ST_RDW,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic seg_load;
    logic seg_next;
    logic step;
    logic pix_rd;
    logic pix_wr;
    logic clr_wr;
    logic rd_issue;
    logic rd_capture;
    logic out_load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic span_zero;
    logic clr_done;
    logic cnt_zero;
    logic seg_last;
    logic in_range;
    logic out_free;
  } ctl_sts_t;

  // bit of a pixel inside its byte, msb first
  function automatic logic [7:0] pixel_mask(input logic [2:0] col);
    pixel_mask = 8'h80 >> col;
  endfunction

endpackage

>>> rtl/core/mono_framebuffer_draw_engine.sv
// mono_framebuffer_draw_engine: top level, register port and controller/datapath
// depends on mfde_pkg, mfde_ctrl and mfde_datapath
`timescale 1ns / 1ps

// 1 bit per pixel frame store with drawing commands.
// input channel: one command word per accept (in_valid_i high, in_stall_o low);
// output channel: exactly one read_data word per command, zero except for reads.
// commands are worked one at a time; in_stall_o is low only while idle.
// per command: a read byte issues a store read, then captures the byte;
// unused codes and empty rectangles go straight to the result word;
// clear writes the cleared bytes, one store write per cycle;
// pixel/lines/outline load each segment and step each pixel, with a
// read-modify-write through the single store port when on screen.
// a finished word waits in the output register; it may stay there while the
// next command is taken, and the engine holds at its end until that register
// frees up when the receiver keeps out_stall_i high.
// after reset the store is swept to zero, one byte per cycle over all
// MAX_WIDTH*MAX_HEIGHT/8 bytes (1024 by default), before the first accept.
// width and height registers sit on the register port at byte 0 and 4.
module mono_framebuffer_draw_engine
  import mfde_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] span_w_i,
  input  logic [15:0] span_h_i,
  input  logic        ink_i,
  input  logic [9:0]  byte_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CFG_W_BITS-1:0] width_q;
  logic [CFG_H_BITS-1:0] height_q;
  ctl_cmd_t              cmd;
  ctl_sts_t              sts;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W_BITS'(128);
      height_q <= CFG_H_BITS'(64);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_WIDTH) begin
        width_q <= pwdata[CFG_W_BITS-1:0];
      end else begin
        height_q <= pwdata[CFG_H_BITS-1:0];
      end
    end
  end

  // register reads
  assign prdata = (paddr[2] == REG_HEIGHT) ? {25'd0, height_q} : {24'd0, width_q};
  assign pready = 1'b1;

  mfde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mfde_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .width_i     (width_q),
    .height_i    (height_q),
    .opcode_i    (opcode_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .span_w_i    (span_w_i),
    .span_h_i    (span_h_i),
    .ink_i       (ink_i),
    .byte_addr_i (byte_addr_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o)
  );

endmodule

>>> rtl/core/mfde_ram.sv
// mfde_ram: generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mfde_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/mfde_datapath.sv
// mfde_datapath: command registers, walk counters, address logic, store and result word
// depends on mfde_pkg and mfde_ram
`timescale 1ns / 1ps

module mfde_datapath #(
  parameter int unsigned MAX_WIDTH  = mfde_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = mfde_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mfde_pkg::ctl_cmd_t              cmd_i,
  output mfde_pkg::ctl_sts_t              sts_o,
  input  logic [mfde_pkg::CFG_W_BITS-1:0] width_i,
  input  logic [mfde_pkg::CFG_H_BITS-1:0] height_i,
  input  logic [2:0]                      opcode_i,
  input  logic [15:0]                     pos_x_i,
  input  logic [15:0]                     pos_y_i,
  input  logic [15:0]                     span_w_i,
  input  logic [15:0]                     span_h_i,
  input  logic                            ink_i,
  input  logic [9:0]                      byte_addr_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      read_data_o
);
  import mfde_pkg::*;

  localparam int unsigned STORE_BYTES = (MAX_WIDTH * MAX_HEIGHT) / 8;
  localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned CW = $clog2(STORE_BYTES + 1);

  // command word
  op_e         op_q;
  logic [15:0] x0_q, y0_q, w_q, h_q;
  logic        ink_q;
  logic [9:0]  baddr_q;
  logic        rd_ok_q;

  // segment walk
  seg_e        seg_q, seg_end_q;
  logic [15:0] cx_q, cy_q, cnt_q;
  logic        col_dir_q;

  // clear sweep
  logic [CW-1:0] ptr_q, lim_q;

  // result word
  logic [7:0] result_q;
  logic       out_valid_q;

  // store port
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;

  // clear length from the configured geometry
  logic [CFG_W_BITS+CFG_H_BITS-1:0] area;
  logic [CW-1:0]                    clr_lim;
  assign area    = (CFG_W_BITS+CFG_H_BITS)'(width_i) * (CFG_W_BITS+CFG_H_BITS)'(height_i);
  assign clr_lim = ((32'(area) >> 3) > 32'(STORE_BYTES)) ? CW'(STORE_BYTES)
                                                         : CW'(area >> 3);

  // current pixel position to byte index
  logic [IDX_W-1:0] idx;
  logic             x_ok, y_ok, idx_ok;
  assign x_ok   = cx_q < {8'd0, width_i};
  assign y_ok   = cy_q < {9'd0, height_i};
  assign idx    = IDX_W'(cy_q[6:0]) * IDX_W'(width_i[7:3]) + IDX_W'(cx_q[7:3]);
  assign idx_ok = 32'(idx) < 32'(STORE_BYTES);

  // command capture and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(opcode_i);
      x0_q    <= pos_x_i;
      y0_q    <= pos_y_i;
      w_q     <= span_w_i;
      h_q     <= span_h_i;
      baddr_q <= byte_addr_i;
      rd_ok_q <= 32'(byte_addr_i) < 32'(STORE_BYTES);
      if (op_e'(opcode_i) == OP_VLINE) begin
        seg_q     <= SEG_LEFT;
        seg_end_q <= SEG_LEFT;
      end else if (op_e'(opcode_i) == OP_RECT) begin
        seg_q     <= SEG_TOP;
        seg_end_q <= SEG_RIGHT;
      end else begin
        seg_q     <= SEG_TOP;
        seg_end_q <= SEG_TOP;
      end
    end else if (cmd_i.seg_next) begin
      seg_q <= seg_e'(seg_q + 2'd1);
    end

    if (cmd_i.seg_load) begin
      case (seg_q)
        SEG_TOP: begin
          cx_q      <= x0_q;
          cy_q      <= y0_q;
          cnt_q     <= (op_q == OP_PIXEL) ? 16'd1 : w_q;
          col_dir_q <= 1'b0;
        end
        SEG_BOTTOM: begin
          cx_q      <= x0_q;
          cy_q      <= y0_q + h_q - 16'd1;
          cnt_q     <= w_q;
          col_dir_q <= 1'b0;
        end
        SEG_LEFT: begin
          cx_q      <= x0_q;
          cy_q      <= y0_q;
          cnt_q     <= h_q;
          col_dir_q <= 1'b1;
        end
        default: begin
          cx_q      <= x0_q + w_q - 16'd1;
          cy_q      <= y0_q;
          cnt_q     <= h_q;
          col_dir_q <= 1'b1;
        end
      endcase
    end else if (cmd_i.step) begin
      if (col_dir_q) begin
        cy_q <= cy_q + 16'd1;
      end else begin
        cx_q <= cx_q + 16'd1;
      end
      cnt_q <= cnt_q - 16'd1;
    end
  end

  // clear sweep and fill value; reset starts a zero fill of the whole store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      lim_q <= CW'(STORE_BYTES);
      ink_q <= 1'b0;
    end else if (cmd_i.load) begin
      ptr_q <= '0;
      lim_q <= clr_lim;
      ink_q <= ink_i;
    end else if (cmd_i.clr_wr) begin
      ptr_q <= ptr_q + CW'(1);
    end
  end

  // store address and write data
  always_comb begin
    mem_we    = cmd_i.pix_wr | cmd_i.clr_wr;
    mem_addr  = AW'(idx);
    mem_wdata = ink_q ? (mem_rdata | pixel_mask(cx_q[2:0]))
                      : (mem_rdata & ~pixel_mask(cx_q[2:0]));
    if (cmd_i.clr_wr) begin
      mem_addr  = ptr_q[AW-1:0];
      mem_wdata = ink_q ? 8'hFF : 8'h00;
    end else if (cmd_i.rd_issue) begin
      mem_addr = AW'(baddr_q);
    end
  end

  mfde_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      result_q <= 8'h00;
    end else if (cmd_i.rd_capture) begin
      result_q <= rd_ok_q ? mem_rdata : 8'h00;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      read_data_o <= result_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // status
  assign sts_o.op        = op_q;
  assign sts_o.span_zero = (w_q == 16'd0) || (h_q == 16'd0);
  assign sts_o.clr_done  = ptr_q >= lim_q;
  assign sts_o.cnt_zero  = cnt_q == 16'd0;
  assign sts_o.seg_last  = seg_q == seg_end_q;
  assign sts_o.in_range  = x_ok && y_ok && idx_ok;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

>>> rtl/core/mfde_ctrl.sv
// mfde_ctrl: sequencer for clear, segment walks, pixel read-modify-write and reads
// depends on mfde_pkg
`timescale 1ns / 1ps

module mfde_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mfde_pkg::ctl_sts_t sts_i,
  output mfde_pkg::ctl_cmd_t cmd_o
);
  import mfde_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: if (sts_i.clr_done) state_d = ST_IDLE;
      ST_IDLE: if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        unique case (sts_i.op) inside
          OP_CLEAR:                    state_d = ST_CLR;
          OP_PIXEL, OP_HLINE, OP_VLINE: state_d = ST_SEG;
          OP_RECT:  state_d = sts_i.span_zero ? ST_DONE : ST_SEG;
          OP_READ:  state_d = ST_RD;
          default:  state_d = ST_DONE;
        endcase
      end
      ST_CLR: if (sts_i.clr_done) state_d = ST_DONE;
      ST_SEG: state_d = ST_PIX;
      ST_PIX: begin
        if (sts_i.cnt_zero) begin
          state_d = sts_i.seg_last ? ST_DONE : ST_SEG;
        end else if (sts_i.in_range) begin
          state_d = ST_WR;
        end
      end
      ST_WR:   state_d = ST_PIX;
      ST_RD:   state_d = ST_RDW;
      ST_RDW:  state_d = ST_DONE;
      ST_DONE: if (sts_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_INIT;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_INIT: cmd_o.clr_wr = !sts_i.clr_done;
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_DECODE: ;
      ST_CLR: cmd_o.clr_wr = !sts_i.clr_done;
      ST_SEG: cmd_o.seg_load = 1'b1;
      ST_PIX: begin
        if (sts_i.cnt_zero) begin
          cmd_o.seg_next = !sts_i.seg_last;
        end else if (sts_i.in_range) begin
          cmd_o.pix_rd = 1'b1;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_WR: begin
        cmd_o.pix_wr = 1'b1;
        cmd_o.step   = 1'b1;
      end
      ST_RD:   cmd_o.rd_issue   = 1'b1;
      ST_RDW:  cmd_o.rd_capture = 1'b1;
      ST_DONE: cmd_o.out_load   = sts_i.out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // at most one store access per cycle
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.pix_rd, cmd_o.pix_wr, cmd_o.clr_wr, cmd_o.rd_issue}))
    else $error("more than one store access in a cycle");

  // a pixel write always uses the byte read the cycle before
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pix_wr |-> $past(cmd_o.pix_rd))
    else $error("pixel write without preceding read");

  // the result register is only loaded when it can take a word
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result overwritten while stalled");

  // an accepted word is decoded next
  a_load_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_DECODE)
    else $error("accepted word not decoded");
`endif

endmodule

>>> tb/testbench.sv
// testbench: self-checking bench for the monochrome framebuffer draw engine
// depends on mfde_pkg and mono_framebuffer_draw_engine; drives commands and
// register writes, predicts every read_data word from its own frame model
`timescale 1ns / 1ps

module testbench;
  import mfde_pkg::*;

  localparam int unsigned STORE_BYTES = 1024;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  opcode_i;
  logic [15:0] pos_x_i;
  logic [15:0] pos_y_i;
  logic [15:0] span_w_i;
  logic [15:0] span_h_i;
  logic        ink_i;
  logic [9:0]  byte_addr_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  read_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // one drawing command
  typedef struct {
    logic [2:0]  op;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic        ink;
    logic [9:0]  addr;
    bit          typed;
    logic [7:0]  typed_data;
  } draw_cmd_t;

  // predicted frame and geometry
  logic [7:0]  pixels_mirror [STORE_BYTES];
  logic [7:0]  width_mirror;
  logic [6:0]  height_mirror;
  logic [7:0]  pending_bytes [$];

  int  err_count;
  int  cycle_count;
  bit  stall_quiet;
  bit  hold_long;
  int  hold_cycles;

  mono_framebuffer_draw_engine dut (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // set or clear one pixel of the mirror
  function automatic void plot_pixel(input logic [15:0] px, input logic [15:0] py,
                                     input logic ink);
    int unsigned idx;
    logic [7:0]  bitm;
    if (px >= width_mirror || py >= height_mirror) return;
    idx = int'(py) * (width_mirror / 8) + int'(px) / 8;
    if (idx >= STORE_BYTES) return;
    bitm = 8'h80 >> px[2:0];
    if (ink) pixels_mirror[idx] = pixels_mirror[idx] | bitm;
    else pixels_mirror[idx] = pixels_mirror[idx] & ~bitm;
  endfunction

  function automatic void plot_row(input logic [15:0] px, input logic [15:0] py,
                                   input logic [15:0] len, input logic ink);
    logic [15:0] xx;
    for (int i = 0; i < int'(len); i++) begin
      xx = px + 16'(i);
      plot_pixel(xx, py, ink);
    end
  endfunction

  function automatic void plot_col(input logic [15:0] px, input logic [15:0] py,
                                   input logic [15:0] len, input logic ink);
    logic [15:0] yy;
    for (int i = 0; i < int'(len); i++) begin
      yy = py + 16'(i);
      plot_pixel(px, yy, ink);
    end
  endfunction

  // apply one command to the mirror, return the word it yields
  function automatic logic [7:0] draw_and_read(input draw_cmd_t c);
    int unsigned n;
    logic [7:0]  rd;
    rd = 8'h00;
    case (c.op)
      OP_CLEAR: begin
        n = (int'(width_mirror) * int'(height_mirror)) / 8;
        if (n > STORE_BYTES) n = STORE_BYTES;
        for (int i = 0; i < int'(n); i++) pixels_mirror[i] = c.ink ? 8'hFF : 8'h00;
      end
      OP_PIXEL: plot_pixel(c.x, c.y, c.ink);
      OP_HLINE: plot_row(c.x, c.y, c.w, c.ink);
      OP_VLINE: plot_col(c.x, c.y, c.h, c.ink);
      OP_RECT: begin
        if (c.w != 0 && c.h != 0) begin
          plot_row(c.x, c.y, c.w, c.ink);
          plot_row(c.x, c.y + c.h - 16'd1, c.w, c.ink);
          plot_col(c.x, c.y, c.h, c.ink);
          plot_col(c.x + c.w - 16'd1, c.y, c.h, c.ink);
        end
      end
      OP_READ: rd = pixels_mirror[c.addr];
      default: ;
    endcase
    return rd;
  endfunction

  // register write through setup and access phases
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == 3'd0) width_mirror = data[7:0];
    else if (addr == 3'd4) height_mirror = data[6:0];
    @(negedge clk_i);
  endtask

  task automatic set_geometry(input logic [7:0] w, input logic [6:0] h);
    write_reg(3'd0, {24'd0, w});
    write_reg(3'd4, {25'd0, h});
  endtask

  // wait for all words, then let the engine go quiet
  task automatic drain_words();
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // offer one command, with random gaps when gaps is set
  task automatic send_cmd(input draw_cmd_t c, input bit gaps);
    logic [7:0] exp_byte;
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= c.op;
    pos_x_i     <= c.x;
    pos_y_i     <= c.y;
    span_w_i    <= c.w;
    span_h_i    <= c.h;
    ink_i       <= c.ink;
    byte_addr_i <= c.addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    exp_byte = draw_and_read(c);
    if (c.typed && exp_byte != c.typed_data) begin
      $display("%0t: table row mismatch expected %02h predicted %02h", $time,
               c.typed_data, exp_byte);
      err_count++;
    end
    pending_bytes.push_back(c.typed ? c.typed_data : exp_byte);
    @(negedge clk_i);
  endtask

  function automatic draw_cmd_t mk(input logic [2:0] op, input logic [15:0] x,
                                   input logic [15:0] y, input logic [15:0] w,
                                   input logic [15:0] h, input logic ink,
                                   input logic [9:0] addr);
    draw_cmd_t c;
    c.op = op; c.x = x; c.y = y; c.w = w; c.h = h; c.ink = ink; c.addr = addr;
    c.typed = 1'b0; c.typed_data = 8'h00;
    return c;
  endfunction

  function automatic draw_cmd_t mk_typed(input draw_cmd_t c, input logic [7:0] d);
    draw_cmd_t r;
    r = c;
    r.typed = 1'b1;
    r.typed_data = d;
    return r;
  endfunction

  // mostly on-screen random command, short spans
  function automatic draw_cmd_t rand_cmd();
    draw_cmd_t c;
    int unsigned k;
    k = $urandom_range(0, 99);
    c = mk(3'($urandom_range(1, 5)), 16'($urandom_range(0, 140)),
           16'($urandom_range(0, 70)), 16'($urandom_range(0, 40)),
           16'($urandom_range(0, 24)), 1'($urandom), 10'($urandom));
    if (k < 4) c.op = OP_CLEAR;
    else if (k < 7) c.op = 3'($urandom_range(6, 7));
    else if (k < 40) c.op = OP_READ;
    if (k >= 90) begin
      // wrap-around coordinates
      c.x = 16'($urandom);
      c.y = 16'($urandom);
      if ($urandom_range(0, 1)) c.x = 16'hFFFF - 16'($urandom_range(0, 20));
      if ($urandom_range(0, 1)) c.y = 16'hFFFF - 16'($urandom_range(0, 20));
      c.w = 16'($urandom_range(0, 40));
      c.h = 16'($urandom_range(0, 40));
    end
    if (k == 99) begin
      // wide span bits, kept to one long line
      c.op = OP_HLINE;
      c.w = 16'($urandom_range(0, 65535));
      c.x = 16'h0000;
      c.y = 16'($urandom_range(0, 63));
      if (c.w > 16'd600) c.w = {6'd0, c.w[9:0]};
    end
    return c;
  endfunction

  // receiver stall pattern
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        for (hold_cycles = 0; hold_cycles < 300; hold_cycles++) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_long = 1'b0;
      end else if (!stall_quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // output word checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %02h", $time, read_data_o);
        err_count++;
      end else begin
        if (read_data_o !== pending_bytes[0]) begin
          $display("%0t: read_data mismatch expected %02h actual %02h", $time,
                   pending_bytes[0], read_data_o);
          err_count++;
        end
        void'(pending_bytes.pop_front());
      end
    end
  end

  // stimulus
  initial begin
    draw_cmd_t dir_rows [$];
    draw_cmd_t c;
    err_count   = 0;
    cycle_count = 0;
    stall_quiet = 1'b1;
    hold_long   = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    opcode_i    = OP_CLEAR;
    pos_x_i = '0; pos_y_i = '0; span_w_i = '0; span_h_i = '0;
    ink_i = 1'b0; byte_addr_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    for (int i = 0; i < STORE_BYTES; i++) pixels_mirror[i] = 8'h00;
    width_mirror  = 8'd128;
    height_mirror = 7'd64;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table: store is zero after reset
    dir_rows.push_back(mk_typed(mk(OP_READ, 0, 0, 0, 0, 0, 10'd0), 8'h00));
    dir_rows.push_back(mk_typed(mk(OP_READ, 0, 0, 0, 0, 0, 10'h3FF), 8'h00));
    dir_rows.push_back(mk_typed(mk(OP_PIXEL, 0, 0, 0, 0, 1, 0), 8'h00));
    dir_rows.push_back(mk_typed(mk(OP_READ, 0, 0, 0, 0, 0, 10'd0), 8'h80));
    dir_rows.push_back(mk(OP_PIXEL, 127, 63, 0, 0, 1, 0));
    dir_rows.push_back(mk_typed(mk(OP_READ, 0, 0, 0, 0, 0, 10'h3FF), 8'h01));
    dir_rows.push_back(mk(OP_PIXEL, 128, 0, 0, 0, 1, 0));
    dir_rows.push_back(mk(OP_PIXEL, 16'hFFFF, 16'hFFFF, 0, 0, 1, 0));
    dir_rows.push_back(mk(OP_HLINE, 16'hFFFC, 2, 8, 0, 1, 0));
    dir_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 10'd32));
    dir_rows.push_back(mk(OP_VLINE, 5, 16'hFFFE, 0, 6, 1, 0));
    dir_rows.push_back(mk(OP_RECT, 10, 10, 0, 5, 1, 0));
    dir_rows.push_back(mk(OP_RECT, 10, 10, 5, 0, 1, 0));
    dir_rows.push_back(mk(OP_RECT, 20, 20, 1, 1, 1, 0));
    dir_rows.push_back(mk(OP_RECT, 30, 30, 12, 7, 1, 0));
    dir_rows.push_back(mk(OP_RECT, 120, 60, 16, 16, 1, 0));
    dir_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 10'd483));
    dir_rows.push_back(mk_typed(mk(3'd6, 0, 0, 0, 0, 1, 0), 8'h00));
    dir_rows.push_back(mk_typed(mk(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
                                   10'h3FF), 8'h00));
    dir_rows.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 1, 0));
    dir_rows.push_back(mk_typed(mk(OP_READ, 0, 0, 0, 0, 0, 10'h3FF), 8'hFF));
    dir_rows.push_back(mk(OP_HLINE, 0, 1, 16'd200, 0, 0, 0));
    dir_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 10'd17));
    dir_rows.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_typed(mk(OP_READ, 0, 0, 0, 0, 0, 10'd5), 8'h00));
    foreach (dir_rows[i]) send_cmd(dir_rows[i], 1'b0);
    drain_words();

    // random phases over several geometries, extremes included
    stall_quiet = 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_geometry(8'd128, 7'd64);
        1: set_geometry(8'd8, 7'd1);
        2: set_geometry(8'd255, 7'd127);
        3: set_geometry(8'd12, 7'd5);
        4: set_geometry(8'd64, 7'd32);
        default: set_geometry(8'($urandom_range(1, 255)), 7'($urandom_range(0, 127)));
      endcase
      for (int n = 0; n < 170; n++) begin
        c = rand_cmd();
        if (ph == 2 && n == 20) hold_long = 1'b1;
        if (ph == 4 && n == 60) begin
          // sender waits for the engine to drain completely
          in_valid_i <= 1'b0;
          @(negedge clk_i);
          while (pending_bytes.size() != 0) @(negedge clk_i);
        end
        send_cmd(c, 1'b1);
      end
      drain_words();
    end

    // final stretch without idling on either side
    stall_quiet = 1'b1;
    set_geometry(8'd128, 7'd64);
    for (int n = 0; n < 150; n++) send_cmd(rand_cmd(), 1'b0);
    drain_words();

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
